// ===== rtl/palette_colour_effect_core_defines.svh =====
// Assertion macros shared by the palette colour effect RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PALETTE_COLOUR_EFFECT_CORE_DEFINES_SVH
`define PALETTE_COLOUR_EFFECT_CORE_DEFINES_SVH
`ifndef SYNTH
`define PCE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pce assertion failed");
`define PCE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pce assertion failed");
`else
`define PCE_ASSERT_IMP(label, ante, cons)
`define PCE_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/pce_pkg.sv =====
// Package for the palette colour effect core: widths, register and mode codes,
// sepia coefficient table, reciprocal constants and shared structs. No dependencies.
package pce_pkg;

	localparam int CH_W      = 8;
	localparam int MODE_W    = 3;
	localparam int PCT_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int COEF_W    = 16;
	localparam int FACTOR_W  = 10;
	localparam int SPROD_W   = CH_W + COEF_W;
	localparam int SSUM_W    = SPROD_W + 2;
	localparam int BPROD_W   = CH_W + FACTOR_W;
	localparam int AVG_SUM_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTEN_PCT = 2'd1;

	localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEPIA    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLUE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RED      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_GRAY     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BRIGHTEN = 3'd5;

	localparam logic [MODE_W-1:0]       MODE_RESET = MODE_NONE;
	localparam logic signed [PCT_W-1:0] PCT_RESET  = 10'sd200;

	// Sepia matrix, unsigned Q0.16, rows are output red, green, blue.
	localparam logic [COEF_W-1:0] SEPIA_COEF [3][3] = '{
		'{16'd25756, 16'd50397, 16'd12386},
		'{16'd22872, 16'd44958, 16'd11010},
		'{16'd17826, 16'd34996, 16'd8585}
	};

	// Division by 100 as a multiply by ceil(2^32/100); exact for the product range.
	localparam int                 RECIP100_W     = 26;
	localparam logic [RECIP100_W-1:0] RECIP100    = 26'd42949673;
	localparam int                 RECIP100_SHIFT = 32;
	localparam int                 BQ_W           = BPROD_W + RECIP100_W;

	// Division by 3 as a multiply by ceil(2^13/3); exact below 8192.
	localparam int                 RECIP3_W     = 12;
	localparam logic [RECIP3_W-1:0] RECIP3      = 12'd2731;
	localparam int                 RECIP3_SHIFT = 13;
	localparam int                 AVG_PROD_W   = AVG_SUM_W + RECIP3_W;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic signed [PCT_W-1:0] percent;
	} pce_cfg_t;

	typedef struct packed {
		logic              valid;
		logic [MODE_W-1:0] mode;
		logic              bright_zero;
	} pce_ctl_t;

endpackage

// ===== rtl/palette_colour_effect_core.sv =====
// Top level of the palette colour effect core: config registers, multiply
// pipeline and output stage. Depends on pce_pkg, pce_cfg_regs, pce_arith, pce_select.
//
// Channel   Handshake                 Payload
// input     start, busy               red_in, green_in, blue_in
// result    done (valid per result)   red_out, green_out, blue_out
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One word is accepted every cycle; busy is never raised.
// Each word passes three multiply stages (input capture, products, then sums and
// reciprocal scaling) and then the output register before its result appears.
// Reset clears the valid bits and returns the registers to mode none, percent 200.
// The receiver cannot stall, so the pipeline always advances.
`include "palette_colour_effect_core_defines.svh"
module palette_colour_effect_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [pce_pkg::CH_W-1:0]       red_in,
	input  logic [pce_pkg::CH_W-1:0]       green_in,
	input  logic [pce_pkg::CH_W-1:0]       blue_in,
	output logic                           done,
	output logic [pce_pkg::CH_W-1:0]       red_out,
	output logic [pce_pkg::CH_W-1:0]       green_out,
	output logic [pce_pkg::CH_W-1:0]       blue_out,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pce_pkg::PCT_W-1:0]      cfg_data
);
	import pce_pkg::*;

	pce_cfg_t                  cfg;
	pce_ctl_t                  ctl_s3;
	logic [2:0][CH_W-1:0]      ch_s3;
	logic [2:0][SSUM_W-1:0]    sepia_s3;
	logic [2:0][BQ_W-1:0]      bright_s3;
	logic [AVG_PROD_W-1:0]     avg_s3;
	logic                      accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	pce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pce_arith u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.red       (red_in),
		.green     (green_in),
		.blue      (blue_in),
		.cfg       (cfg),
		.ctl_s3    (ctl_s3),
		.ch_s3     (ch_s3),
		.sepia_s3  (sepia_s3),
		.bright_s3 (bright_s3),
		.avg_s3    (avg_s3)
	);

	pce_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s3    (ctl_s3),
		.ch_s3     (ch_s3),
		.sepia_s3  (sepia_s3),
		.bright_s3 (bright_s3),
		.avg_s3    (avg_s3),
		.done      (done),
		.red       (red_out),
		.green     (green_out),
		.blue      (blue_out)
	);

	// Every result strobe traces back to an accepted word.
	`PCE_ASSERT_IMP(a_done_latency, done, $past(start, 4))

endmodule

// ===== rtl/pce_cfg_regs.sv =====
// Configuration registers of the palette colour effect core.
// Depends on pce_pkg.
module pce_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pce_pkg::PCT_W-1:0]      cfg_data,
	output pce_pkg::pce_cfg_t              cfg
);
	import pce_pkg::*;

	logic [MODE_W-1:0]       mode_q;
	logic signed [PCT_W-1:0] percent_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			percent_q <= PCT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EFFECT_MODE:  mode_q    <= cfg_data[MODE_W-1:0];
				REG_BRIGHTEN_PCT: percent_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg.mode    = mode_q;
	assign cfg.percent = percent_q;

endmodule

// ===== rtl/pce_arith.sv =====
// Multiply pipeline (stages 1 to 3): sepia products and sums, brighten products
// scaled by 1/100, channel sum scaled by 1/3. Depends on pce_pkg.
module pce_arith (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic [pce_pkg::CH_W-1:0]               red,
	input  logic [pce_pkg::CH_W-1:0]               green,
	input  logic [pce_pkg::CH_W-1:0]               blue,
	input  pce_pkg::pce_cfg_t                      cfg,
	output pce_pkg::pce_ctl_t                      ctl_s3,
	output logic [2:0][pce_pkg::CH_W-1:0]          ch_s3,
	output logic [2:0][pce_pkg::SSUM_W-1:0]        sepia_s3,
	output logic [2:0][pce_pkg::BQ_W-1:0]          bright_s3,
	output logic [pce_pkg::AVG_PROD_W-1:0]         avg_s3
);
	import pce_pkg::*;

	logic signed [PCT_W:0]               factor_full;
	pce_ctl_t                            ctl_s1, ctl_s2;
	logic [2:0][CH_W-1:0]                ch_s1, ch_s2;
	logic [FACTOR_W-1:0]                 factor_s1;
	logic [2:0][2:0][SPROD_W-1:0]        sprod_s2;
	logic [2:0][BPROD_W-1:0]             bprod_s2;
	logic [AVG_SUM_W-1:0]                sum_s2;

	assign factor_full = (PCT_W+1)'(signed'(100)) + (PCT_W+1)'(cfg.percent);

	// Control travels with the data; the pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1.valid       <= accept;
			ctl_s1.mode        <= cfg.mode;
			ctl_s1.bright_zero <= (factor_full <= 0);
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1     <= {blue, green, red};
		factor_s1 <= factor_full[FACTOR_W-1:0];
		ch_s2     <= ch_s1;
		ch_s3     <= ch_s2;
		sum_s2    <= AVG_SUM_W'(ch_s1[0]) + AVG_SUM_W'(ch_s1[1]) + AVG_SUM_W'(ch_s1[2]);
		avg_s3    <= AVG_PROD_W'(sum_s2) * AVG_PROD_W'(RECIP3);
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sprod_s2[r][c] <= SPROD_W'(ch_s1[c]) * SPROD_W'(SEPIA_COEF[r][c]);
			end
			bprod_s2[r]  <= BPROD_W'(ch_s1[r]) * BPROD_W'(factor_s1);
			sepia_s3[r]  <= SSUM_W'(sprod_s2[r][0]) + SSUM_W'(sprod_s2[r][1])
			              + SSUM_W'(sprod_s2[r][2]);
			bright_s3[r] <= BQ_W'(bprod_s2[r]) * BQ_W'(RECIP100);
		end
	end

endmodule

// ===== rtl/pce_select.sv =====
// Output stage: shifts, clamps and effect selection into the result registers.
// Depends on pce_pkg and palette_colour_effect_core_defines.svh.
`include "palette_colour_effect_core_defines.svh"
module pce_select (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pce_pkg::pce_ctl_t                      ctl_s3,
	input  logic [2:0][pce_pkg::CH_W-1:0]          ch_s3,
	input  logic [2:0][pce_pkg::SSUM_W-1:0]        sepia_s3,
	input  logic [2:0][pce_pkg::BQ_W-1:0]          bright_s3,
	input  logic [pce_pkg::AVG_PROD_W-1:0]         avg_s3,
	output logic                                   done,
	output logic [pce_pkg::CH_W-1:0]               red,
	output logic [pce_pkg::CH_W-1:0]               green,
	output logic [pce_pkg::CH_W-1:0]               blue
);
	import pce_pkg::*;

	localparam int SEP_Q_W = SSUM_W - COEF_W;
	localparam int BRI_Q_W = BQ_W - RECIP100_SHIFT;

	logic [2:0][CH_W-1:0]  sepia_ch, bright_ch, res;
	logic [SEP_Q_W-1:0]    sep_q [3];
	logic [BRI_Q_W-1:0]    bri_q [3];
	logic [CH_W-1:0]       avg;
	logic                  done_s4;
	logic [2:0][CH_W-1:0]  res_s4;

	assign avg = avg_s3[RECIP3_SHIFT +: CH_W];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sep_q[i]     = sepia_s3[i][SSUM_W-1:COEF_W];
			bri_q[i]     = bright_s3[i][BQ_W-1:RECIP100_SHIFT];
			sepia_ch[i]  = (sep_q[i] > SEP_Q_W'(CH_MAX)) ? CH_MAX : sep_q[i][CH_W-1:0];
			bright_ch[i] = ctl_s3.bright_zero ? '0 :
			               (bri_q[i] > BRI_Q_W'(CH_MAX)) ? CH_MAX : bri_q[i][CH_W-1:0];
		end
		res = ch_s3;
		case (ctl_s3.mode)
			MODE_SEPIA:    res = sepia_ch;
			MODE_BLUE:     res = {ch_s3[2], avg, avg};
			MODE_RED:      res = {avg, avg, ch_s3[0]};
			MODE_GRAY:     res = {avg, avg, avg};
			MODE_BRIGHTEN: res = bright_ch;
			default:       res = ch_s3;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s4 <= res;
	end

	assign done  = done_s4;
	assign red   = res_s4[0];
	assign green = res_s4[1];
	assign blue  = res_s4[2];

	`PCE_ASSERT_NXT(a_gray_equal, ctl_s3.valid && ctl_s3.mode == MODE_GRAY, red == green && green == blue)
	`PCE_ASSERT_NXT(a_bright_zero, ctl_s3.valid && ctl_s3.mode == MODE_BRIGHTEN && ctl_s3.bright_zero, red == '0 && green == '0 && blue == '0)

endmodule

// ===== verif/tb_palette_colour_effect_core.sv =====
// Self-checking testbench for palette_colour_effect_core: directed and random colour
// entries under every effect, checked against an in-bench recolouring model.
// Depends on pce_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_palette_colour_effect_core;
	import pce_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 16;

	// Codes the package leaves unnamed: spare modes and spare register slots.
	localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} colour_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [CH_W-1:0]      red_in;
	logic [CH_W-1:0]      green_in;
	logic [CH_W-1:0]      blue_in;
	logic                 done;
	logic [CH_W-1:0]      red_out;
	logic [CH_W-1:0]      green_out;
	logic [CH_W-1:0]      blue_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PCT_W-1:0]     cfg_data;

	logic [MODE_W-1:0]       mode_copy;
	logic signed [PCT_W-1:0] percent_copy;
	colour_t                 pending_colours[$];
	colour_t                 oldest_colour;
	int                      error_count;
	int                      cycle_count;
	int                      sender_idle_pct;

	logic [MODE_W-1:0] all_modes [8] = '{MODE_NONE, MODE_SEPIA, MODE_BLUE, MODE_RED,
		MODE_GRAY, MODE_BRIGHTEN, MODE_SPARE_LO, MODE_SPARE_HI};
	int edge_percents [6] = '{-512, -101, -100, 0, 400, 511};

	palette_colour_effect_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [CH_W-1:0] clamp_channel(int value);
		if (value > 255)
			return CH_MAX;
		return CH_W'(value);
	endfunction

	function automatic logic [CH_W-1:0] brighten_channel(logic [CH_W-1:0] ch,
			logic signed [PCT_W-1:0] pct);
		int factor;
		int level;
		factor = 100 + int'(pct);
		level = int'(ch);
		if (factor <= 0)
			return '0;
		return clamp_channel((level * factor) / 100);
	endfunction

	function automatic colour_t recolour(colour_t c, logic [MODE_W-1:0] mode,
			logic signed [PCT_W-1:0] pct);
		int r;
		int g;
		int b;
		int avg;
		colour_t res;
		r = int'(c.red);
		g = int'(c.green);
		b = int'(c.blue);
		avg = (r + g + b) / 3;
		res = c;
		case (mode)
			MODE_SEPIA: begin
				res.red   = clamp_channel((r * 25756 + g * 50397 + b * 12386) >> 16);
				res.green = clamp_channel((r * 22872 + g * 44958 + b * 11010) >> 16);
				res.blue  = clamp_channel((r * 17826 + g * 34996 + b * 8585) >> 16);
			end
			MODE_BLUE: begin
				res.red   = CH_W'(avg);
				res.green = CH_W'(avg);
			end
			MODE_RED: begin
				res.green = CH_W'(avg);
				res.blue  = CH_W'(avg);
			end
			MODE_GRAY: begin
				res.red   = CH_W'(avg);
				res.green = CH_W'(avg);
				res.blue  = CH_W'(avg);
			end
			MODE_BRIGHTEN: begin
				res.red   = brighten_channel(c.red, pct);
				res.green = brighten_channel(c.green, pct);
				res.blue  = brighten_channel(c.blue, pct);
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_colours.size() == 0)
				report_mismatch("result word with no entry pending");
			else begin
				oldest_colour = pending_colours.pop_front();
				if (red_out !== oldest_colour.red)
					report_mismatch($sformatf("red_out %0d, expected %0d",
						red_out, oldest_colour.red));
				if (green_out !== oldest_colour.green)
					report_mismatch($sformatf("green_out %0d, expected %0d",
						green_out, oldest_colour.green));
				if (blue_out !== oldest_colour.blue)
					report_mismatch($sformatf("blue_out %0d, expected %0d",
						blue_out, oldest_colour.blue));
			end
		end
	end

	// Leaves start high after acceptance so back-to-back words need no extra edge.
	task automatic send_entry(colour_t c);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			start    <= 1'b0;
			red_in   <= CH_W'($urandom);
			green_in <= CH_W'($urandom);
			blue_in  <= CH_W'($urandom);
		end
		@(negedge clk);
		start    <= 1'b1;
		red_in   <= c.red;
		green_in <= c.green;
		blue_in  <= c.blue;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_colours.push_back(recolour(c, mode_copy, percent_copy));
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_colours.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [PCT_W-1:0] data);
		wait_for_drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_EFFECT_MODE)
			mode_copy = data[MODE_W-1:0];
		else if (idx == REG_BRIGHTEN_PCT)
			percent_copy = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic colour_t make_colour(int r, int g, int b);
		colour_t c;
		c.red   = CH_W'(r);
		c.green = CH_W'(g);
		c.blue  = CH_W'(b);
		return c;
	endfunction

	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CH_MAX;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic logic [PCT_W-1:0] random_percent();
		case ($urandom_range(0, 5))
			0: return PCT_W'(edge_percents[$urandom_range(0, 5)]);
			1: return PCT_W'($urandom);
			default: return PCT_W'(int'($urandom_range(0, 500)) - 100);
		endcase
	endfunction

	// Mode none and percent 200 hold out of reset; brighten is checked before
	// the percent register is ever written.
	task automatic test_reset_state();
		send_entry(make_colour(255, 255, 255));
		send_entry(make_colour(200, 13, 100));
		write_register(REG_EFFECT_MODE, PCT_W'(MODE_BRIGHTEN));
		send_entry(make_colour(200, 13, 100));
	endtask

	task automatic test_each_mode();
		foreach (all_modes[i]) begin
			write_register(REG_EFFECT_MODE, PCT_W'(all_modes[i]));
			send_entry(make_colour(255, 255, 255));
			send_entry(make_colour(200, 13, 100));
		end
	endtask

	// Covers factors that are negative, exactly zero, unity and far above the clamp.
	task automatic test_brighten_extremes();
		write_register(REG_EFFECT_MODE, PCT_W'(MODE_BRIGHTEN));
		foreach (edge_percents[i]) begin
			write_register(REG_BRIGHTEN_PCT, PCT_W'(edge_percents[i]));
			send_entry(make_colour(255, 1, 99));
		end
	endtask

	// Writes to the spare register slots must leave both registers untouched.
	task automatic test_spare_registers();
		write_register(REG_SPARE_LO, PCT_W'($urandom));
		write_register(REG_SPARE_HI, PCT_W'($urandom));
		send_entry(make_colour(200, 13, 100));
		send_entry(make_colour(0, 0, 0));
	endtask

	task automatic test_random_traffic(int entries, int idle_pct);
		int until_reconfig;
		sender_idle_pct = idle_pct;
		until_reconfig = 0;
		for (int n = 0; n < entries; n++) begin
			if (until_reconfig == 0) begin
				// Upper data bits are random on a mode write; only the low bits land.
				write_register(REG_EFFECT_MODE, PCT_W'($urandom));
				if ($urandom_range(0, 1))
					write_register(REG_BRIGHTEN_PCT, random_percent());
				until_reconfig = $urandom_range(15, 40);
			end
			until_reconfig--;
			send_entry({random_channel(), random_channel(), random_channel()});
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		red_in          = '0;
		green_in        = '0;
		blue_in         = '0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		mode_copy       = MODE_RESET;
		percent_copy    = PCT_RESET;
		error_count     = 0;
		sender_idle_pct = 36;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_each_mode();
		test_brighten_extremes();
		test_spare_registers();
		test_random_traffic(250, 36);
		test_random_traffic(250, 88);
		test_random_traffic(250, 0);

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
